>>> hw/rtl/pafl_pkg.sv
`default_nettype none

package pafl_pkg;

  // Fixed field widths
  localparam int ADDR_W = 32;
  localparam int PAGE_W = 20;
  localparam int END_W  = 21;
  localparam int LIM_W  = 22;

  // Largest legal region end: one past the last 20-bit page
  localparam logic [END_W-1:0] END_MAX = END_W'(1) << PAGE_W;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_PAGES  = 1024;
  localparam int DEF_PAGE_SHIFT = 12;

  typedef enum logic [1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_ALLOC_AT = 2'd1,
    CMD_FREE     = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OOM    = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_BEGIN = 1'b0,
    REG_END   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    status_t           status;
    logic              map_request;
  } rsp_t;

  typedef struct packed {
    cfg_reg_t         reg_index;
    logic [END_W-1:0] wr_data;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic commit;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/pafl_stream_if.sv
`default_nettype none

interface pafl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/page_allocator_free_list_top.sv
// Channel  Dir  Payload                          Handshake
// in_ch    in   cmd, address                     valid/ready
// out_ch   out  page, status, map_request        valid/ready
// cfg_ch   in   reg_index, wr_data               valid/ready, always ready
//
// Each request is accepted, then executed and loaded into the result register;
// the link memory's registered read lies between the two steps.
// A new request is taken while the previous result waits in the output register.
// A stalled result holds the execute step, so the input stays blocked until out_ch drains.
// Reset (rst_n low, synchronous) clears region, bump pointer and free list; no memory sweep.
`default_nettype none

module page_allocator_free_list_top
  import pafl_pkg::*;
#(
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  pafl_stream_if.sink    in_ch,
  pafl_stream_if.source  out_ch,
  pafl_stream_if.sink    cfg_ch
);

  ctl_t ctl;
  sts_t sts;
  logic in_ready;
  logic out_valid;
  rsp_t out_data;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  pafl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  pafl_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .cfg_fire  (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

`default_nettype wire

>>> hw/rtl/pafl_ram.sv
`default_nettype none

module pafl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pafl_ctrl.sv
`default_nettype none

module pafl_ctrl
  import pafl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Take a request only when no request is in flight
  assign in_ready   = (state_r == S_IDLE);
  assign ctl.accept = in_valid && (state_r == S_IDLE);
  assign ctl.commit = (state_r == S_EXEC) && sts.out_free;

  // Advance: IDLE -> EXEC on accept, EXEC -> IDLE once the result is loaded
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pafl_dp.sv
`default_nettype none

module pafl_dp
  import pafl_pkg::*;
#(
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire req_t in_data,
  input  wire logic cfg_fire,
  input  wire cfg_t cfg_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_data,
  input  wire ctl_t ctl,
  output sts_t      sts
);

  localparam int OFF_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int LINK_W = OFF_W + 1;

  // Region and allocator state
  logic [PAGE_W-1:0] begin_r, begin_nxt;
  logic [END_W-1:0]  end_r, end_nxt;
  logic [LIM_W-1:0]  limit_r, limit_nxt;
  logic [END_W-1:0]  bump_r, bump_nxt;
  logic [PAGE_W-1:0] head_r, head_nxt;
  logic              nonempty_r, nonempty_nxt;

  // Request in flight and result register
  cmd_t              cmd_r;
  logic [ADDR_W-1:0] addr_r;
  rsp_t              rsp_r, rsp_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Link memory ports
  logic              ram_we;
  logic [OFF_W-1:0]  ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic [OFF_W-1:0]  ram_raddr;
  logic [LINK_W-1:0] ram_rdata;

  logic [ADDR_W-1:0] apage_x;
  logic [LIM_W-1:0]  lim_sum;
  logic              free_bad;
  logic [OFF_W-1:0]  head_off;

  pafl_ram #(
    .WIDTH(LINK_W),
    .DEPTH(MAX_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid    = out_valid_r;
  assign out_data     = rsp_r;
  assign sts.out_free = !out_valid_r || out_ready;

  // Page of the latched address, widened for compares
  assign apage_x  = ADDR_W'(addr_r >> PAGE_SHIFT);
  assign free_bad = (apage_x < ADDR_W'(begin_r)) || (apage_x >= ADDR_W'(limit_r));
  assign head_off = OFF_W'(head_r - begin_r);

  // Limit is min(end, begin + MAX_PAGES), refreshed every cycle
  assign lim_sum   = LIM_W'(begin_r) + LIM_W'(MAX_PAGES);
  assign limit_nxt = (LIM_W'(end_r) < lim_sum) ? LIM_W'(end_r) : lim_sum;

  // Read the head's link as the request is accepted
  assign ram_raddr = head_off;

  // Push: link the new page to the old head
  assign ram_we    = ctl.commit && (cmd_r == CMD_FREE) && !free_bad;
  assign ram_waddr = OFF_W'(apage_x - ADDR_W'(begin_r));
  assign ram_wdata = {nonempty_r, head_off};

  always_comb begin
    begin_nxt     = begin_r;
    end_nxt       = end_r;
    bump_nxt      = bump_r;
    head_nxt      = head_r;
    nonempty_nxt  = nonempty_r;
    rsp_nxt       = rsp_r;
    out_valid_nxt = out_valid_r;

    // Drop the result once taken
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    // Execute the request and load the result
    if (ctl.commit) begin
      out_valid_nxt       = 1'b1;
      rsp_nxt.page        = '0;
      rsp_nxt.status      = ST_OK;
      rsp_nxt.map_request = 1'b0;
      case (cmd_r)
        CMD_ALLOC: begin
          if (nonempty_r) begin
            rsp_nxt.page = head_r;
            if (ram_rdata[OFF_W]) begin
              head_nxt = PAGE_W'(begin_r + PAGE_W'(ram_rdata[OFF_W-1:0]));
            end else begin
              head_nxt     = '0;
              nonempty_nxt = 1'b0;
            end
          end else if (LIM_W'(bump_r) >= limit_r) begin
            rsp_nxt.status = ST_OOM;
          end else begin
            rsp_nxt.page        = PAGE_W'(bump_r);
            rsp_nxt.map_request = 1'b1;
            bump_nxt            = bump_r + END_W'(1);
          end
        end
        CMD_ALLOC_AT: begin
          if (apage_x >= ADDR_W'(end_r)) begin
            rsp_nxt.status = ST_OOM;
          end else begin
            rsp_nxt.page        = PAGE_W'(apage_x);
            rsp_nxt.map_request = 1'b1;
          end
        end
        CMD_FREE: begin
          if (free_bad) begin
            rsp_nxt.status = ST_REJECT;
          end else begin
            rsp_nxt.page = PAGE_W'(apage_x);
            head_nxt     = PAGE_W'(apage_x);
            nonempty_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Register writes; begin reloads the bump pointer and empties the list
    if (cfg_fire) begin
      unique case (cfg_data.reg_index)
        REG_BEGIN: begin
          begin_nxt    = PAGE_W'(cfg_data.wr_data);
          bump_nxt     = END_W'(PAGE_W'(cfg_data.wr_data));
          head_nxt     = '0;
          nonempty_nxt = 1'b0;
        end
        REG_END: begin
          end_nxt = (cfg_data.wr_data > END_MAX) ? END_MAX : cfg_data.wr_data;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      begin_r     <= '0;
      end_r       <= '0;
      limit_r     <= '0;
      bump_r      <= '0;
      head_r      <= '0;
      nonempty_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      begin_r     <= begin_nxt;
      end_r       <= end_nxt;
      limit_r     <= limit_nxt;
      bump_r      <= bump_nxt;
      head_r      <= head_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Latch the request payload on accept, and register the result
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r  <= in_data.cmd;
      addr_r <= in_data.address;
    end
    rsp_r <= rsp_nxt;
  end

  a_begin_reload: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire && (cfg_data.reg_index == REG_BEGIN)
    |=> !nonempty_r && (bump_r == END_W'(begin_r)))
    else $error("begin write did not reload bump pointer and empty the list");

  a_bump_above_begin: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r >= END_W'(begin_r))
    else $error("bump pointer below region begin");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (rsp_r.status != ST_OK) |-> (rsp_r.page == '0) && !rsp_r.map_request)
    else $error("failed request carries a page or a map request");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ctl.accept)
    else $error("link write and link read in the same cycle");

endmodule

`default_nettype wire
